>>> rtl/panel_init_sequence_parser_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef PANEL_INIT_SEQUENCE_PARSER_MACROS_SVH
`define PANEL_INIT_SEQUENCE_PARSER_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define PISP_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define PISP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

>>> rtl/pisp_pkg.sv
package pisp_pkg;

  localparam int unsigned MAX_PARAMS  = 15;
  localparam int unsigned STORE_DEPTH = MAX_PARAMS + 1;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned KIND_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MS_CODE     = 2'd0,
    CFG_US_CODE     = 2'd1,
    CFG_RST_CODE    = 2'd2,
    CFG_RST_PRESENT = 2'd3
  } pisp_cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CMD   = 3'd0,
    KIND_MS    = 3'd1,
    KIND_US    = 3'd2,
    KIND_RST   = 3'd3,
    KIND_NORST = 3'd4,
    KIND_ERR   = 3'd5
  } pisp_kind_t;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_COUNT,
    PH_PARAMS,
    PH_MS,
    PH_US,
    PH_RST,
    PH_HALT
  } pisp_phase_t;

  typedef enum logic {
    ST_PARSE,
    ST_EMIT
  } pisp_state_t;

  localparam logic [WORD_W-1:0] MS_CODE_RST  = 32'hFFFF_FFFD;
  localparam logic [WORD_W-1:0] US_CODE_RST  = 32'hFFFF_FFFE;
  localparam logic [WORD_W-1:0] RST_CODE_RST = 32'hFFFF_FFFF;

  typedef struct packed {
    logic code_ms;
    logic code_us;
    logic code_rst;
    logic rst_present;
    logic count_over;
    logic count_zero;
    logic params_done;
    logic emit_last;
    logic out_free;
  } pisp_status_t;

  typedef struct packed {
    logic       clear_counts;
    logic       store_first;
    logic       set_count;
    logic       store_param;
    logic       load_single;
    pisp_kind_t single_kind;
    logic       emit_start;
    logic       emit_word;
  } pisp_cmd_t;

endpackage

>>> rtl/pisp_if.sv
interface pisp_req_if;
  logic                          valid;
  logic                          ready;
  logic [pisp_pkg::WORD_W-1:0]   seq_word;
  logic                          sequence_start;

  modport source (output valid, output seq_word, output sequence_start, input ready);
  modport sink   (input valid, input seq_word, input sequence_start, output ready);
endinterface

interface pisp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pisp_pkg::KIND_W-1:0]   result_kind;
  logic [pisp_pkg::WORD_W-1:0]   result_value;
  logic                          run_last;

  modport source (output valid, output result_kind, output result_value, output run_last,
                  input ready);
  modport sink   (input valid, input result_kind, input result_value, input run_last,
                  output ready);
endinterface

>>> rtl/pisp_ctrl.sv
module pisp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   sequence_start,
  output logic                   req_ready,
  input  pisp_pkg::pisp_status_t status,
  output pisp_pkg::pisp_cmd_t    cmd
);

  pisp_pkg::pisp_state_t state, state_next;
  pisp_pkg::pisp_phase_t phase, phase_next;
  pisp_pkg::pisp_phase_t eff_phase;
  logic                  accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pisp_pkg::ST_PARSE;
      phase <= pisp_pkg::PH_CMD;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign req_ready = (state == pisp_pkg::ST_PARSE) && status.out_free;
  assign accept    = req_valid && req_ready;
  // a sequence start parses its word as a fresh command position
  assign eff_phase = sequence_start ? pisp_pkg::PH_CMD : phase;

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    cmd              = '0;
    cmd.single_kind  = pisp_pkg::KIND_CMD;
    unique case (state)
      pisp_pkg::ST_PARSE: begin
        if (accept) begin
          cmd.clear_counts = sequence_start;
          unique case (eff_phase)
            pisp_pkg::PH_CMD: begin
              priority if (status.code_ms) begin
                phase_next = pisp_pkg::PH_MS;
              end else if (status.code_us) begin
                phase_next = pisp_pkg::PH_US;
              end else if (status.code_rst) begin
                phase_next = pisp_pkg::PH_RST;
              end else begin
                cmd.store_first = 1'b1;
                phase_next      = pisp_pkg::PH_COUNT;
              end
            end
            pisp_pkg::PH_COUNT: begin
              if (status.count_over) begin
                cmd.load_single  = 1'b1;
                cmd.single_kind  = pisp_pkg::KIND_ERR;
                cmd.clear_counts = 1'b1;
                phase_next       = pisp_pkg::PH_HALT;
              end else begin
                cmd.set_count = 1'b1;
                if (status.count_zero) begin
                  cmd.emit_start = 1'b1;
                  state_next     = pisp_pkg::ST_EMIT;
                  phase_next     = pisp_pkg::PH_CMD;
                end else begin
                  phase_next = pisp_pkg::PH_PARAMS;
                end
              end
            end
            pisp_pkg::PH_PARAMS: begin
              cmd.store_param = 1'b1;
              if (status.params_done) begin
                cmd.emit_start = 1'b1;
                state_next     = pisp_pkg::ST_EMIT;
                phase_next     = pisp_pkg::PH_CMD;
              end
            end
            pisp_pkg::PH_MS: begin
              cmd.load_single = 1'b1;
              cmd.single_kind = pisp_pkg::KIND_MS;
              phase_next      = pisp_pkg::PH_CMD;
            end
            pisp_pkg::PH_US: begin
              cmd.load_single = 1'b1;
              cmd.single_kind = pisp_pkg::KIND_US;
              phase_next      = pisp_pkg::PH_CMD;
            end
            pisp_pkg::PH_RST: begin
              cmd.load_single = 1'b1;
              cmd.single_kind = status.rst_present ? pisp_pkg::KIND_RST
                                                   : pisp_pkg::KIND_NORST;
              phase_next      = pisp_pkg::PH_CMD;
            end
            pisp_pkg::PH_HALT: begin
              // drop everything until the next sequence start
            end
            default: begin
              phase_next = pisp_pkg::PH_CMD;
            end
          endcase
        end
      end
      pisp_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_word = 1'b1;
          if (status.emit_last) begin
            cmd.clear_counts = 1'b1;
            state_next       = pisp_pkg::ST_PARSE;
          end
        end
      end
      default: begin
        state_next = pisp_pkg::ST_PARSE;
      end
    endcase
  end

endmodule

>>> rtl/pisp_dpath.sv
module pisp_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pisp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pisp_pkg::WORD_W-1:0]           cfg_data,
  input  logic [pisp_pkg::WORD_W-1:0]           seq_word,
  input  pisp_pkg::pisp_cmd_t                   cmd,
  output pisp_pkg::pisp_status_t                status,
  input  logic                                  rsp_ready,
  output logic                                  rsp_valid,
  output logic [pisp_pkg::KIND_W-1:0]           result_kind,
  output logic [pisp_pkg::WORD_W-1:0]           result_value,
  output logic                                  run_last
);

  logic [pisp_pkg::WORD_W-1:0] ms_code;
  logic [pisp_pkg::WORD_W-1:0] us_code;
  logic [pisp_pkg::WORD_W-1:0] rst_code;
  logic                        rst_present;

  logic [pisp_pkg::WORD_W-1:0] store [pisp_pkg::STORE_DEPTH];
  logic [pisp_pkg::CNT_W-1:0]  fill_count;
  logic [pisp_pkg::CNT_W-1:0]  expected_count;
  logic [pisp_pkg::IDX_W-1:0]  emit_idx;
  logic                        store_we;
  logic [pisp_pkg::IDX_W-1:0]  store_addr;
  logic [pisp_pkg::CNT_W-1:0]  fill_inc;
  logic [pisp_pkg::CNT_W-1:0]  emit_pos;
  logic [pisp_pkg::WORD_W-1:0] single_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_code     <= pisp_pkg::MS_CODE_RST;
      us_code     <= pisp_pkg::US_CODE_RST;
      rst_code    <= pisp_pkg::RST_CODE_RST;
      rst_present <= 1'b0;
    end else if (cfg_we) begin
      unique case (pisp_pkg::pisp_cfg_idx_t'(cfg_index))
        pisp_pkg::CFG_MS_CODE:     ms_code     <= cfg_data;
        pisp_pkg::CFG_US_CODE:     us_code     <= cfg_data;
        pisp_pkg::CFG_RST_CODE:    rst_code    <= cfg_data;
        pisp_pkg::CFG_RST_PRESENT: rst_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign store_we   = cmd.store_first || cmd.store_param;
  assign store_addr = cmd.store_first ? '0 : fill_count[pisp_pkg::IDX_W-1:0];
  assign fill_inc   = fill_count + pisp_pkg::CNT_W'(1);
  assign emit_pos   = pisp_pkg::CNT_W'(emit_idx) + pisp_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_addr] <= seq_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      expected_count <= '0;
      emit_idx       <= '0;
    end else begin
      priority if (cmd.store_first) begin
        fill_count <= pisp_pkg::CNT_W'(1);
      end else if (cmd.store_param) begin
        fill_count <= fill_inc;
      end else if (cmd.clear_counts) begin
        fill_count <= '0;
      end
      priority if (cmd.set_count) begin
        // count is known to be at most MAX_PARAMS here
        expected_count <= seq_word[pisp_pkg::CNT_W-1:0] + pisp_pkg::CNT_W'(1);
      end else if (cmd.clear_counts) begin
        expected_count <= '0;
      end
      priority if (cmd.emit_start) begin
        emit_idx <= '0;
      end else if (cmd.emit_word) begin
        emit_idx <= emit_idx + pisp_pkg::IDX_W'(1);
      end
    end
  end

  always_comb begin
    unique case (cmd.single_kind)
      pisp_pkg::KIND_MS,
      pisp_pkg::KIND_US,
      pisp_pkg::KIND_ERR:   single_value = seq_word;
      pisp_pkg::KIND_RST:   single_value = {{(pisp_pkg::WORD_W-1){1'b0}}, |seq_word};
      pisp_pkg::KIND_NORST: single_value = '0;
      default:              single_value = '0;
    endcase
  end

  // output register: hold until taken, reload when free
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_single || cmd.emit_word) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_word) begin
      result_kind  <= pisp_pkg::KIND_CMD;
      result_value <= store[emit_idx];
      run_last     <= (emit_pos == expected_count);
    end else if (cmd.load_single) begin
      result_kind  <= cmd.single_kind;
      result_value <= single_value;
      run_last     <= 1'b1;
    end
  end

  assign status.code_ms     = (seq_word == ms_code);
  assign status.code_us     = (seq_word == us_code);
  assign status.code_rst    = (seq_word == rst_code);
  assign status.rst_present = rst_present;
  assign status.count_over  = (seq_word > pisp_pkg::WORD_W'(pisp_pkg::MAX_PARAMS));
  assign status.count_zero  = (seq_word == '0);
  assign status.params_done = (fill_inc >= expected_count);
  assign status.emit_last   = (emit_pos == expected_count);
  assign status.out_free    = !rsp_valid || rsp_ready;

endmodule

>>> rtl/panel_init_sequence_parser.sv
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    seq_word[31:0], sequence_start
// rsp      out  valid/ready    result_kind[2:0], result_value[31:0], run_last
// cfg      in   cfg_we only    cfg_index[1:0], cfg_data[31:0]
//
// A word is taken while the parser is parsing and the output register is free or being drained.
// A completed command with n parameters leaves as n+1 results, one buffer read per
// cycle while rsp is not stalled, through the output register; req.ready stays low until the last is loaded.
// Delay, reset-line and error requests give one result straight from the accepting cycle.
// Synchronous reset restores the codes and returns the parser to the command position.
// A stalled rsp holds its result; the parser waits on the same register.
module panel_init_sequence_parser (
  input  logic                           clk,
  input  logic                           rst,
  pisp_req_if.sink                       req,
  pisp_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [pisp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pisp_pkg::WORD_W-1:0]    cfg_data
);

  pisp_pkg::pisp_status_t status;
  pisp_pkg::pisp_cmd_t    cmd;

  pisp_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req.valid),
    .sequence_start (req.sequence_start),
    .req_ready      (req.ready),
    .status         (status),
    .cmd            (cmd)
  );

  pisp_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .seq_word     (req.seq_word),
    .cmd          (cmd),
    .status       (status),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .result_kind  (rsp.result_kind),
    .result_value (rsp.result_value),
    .run_last     (rsp.run_last)
  );

endmodule

>>> rtl/pisp_checker.sv
`include "panel_init_sequence_parser_macros.svh"

module pisp_props (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [pisp_pkg::KIND_W-1:0]   result_kind,
  input logic [pisp_pkg::WORD_W-1:0]   result_value,
  input logic                          run_last
);

  `PISP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(result_kind) && $stable(result_value) && $stable(run_last), "stalled result changed")

  // while a run is still going out, no new word may enter
  `PISP_ASSERT_NOW(a_run_blocks_req, rsp_valid && !run_last, !req_ready, "word taken during a run")

  // a single request result only follows an accepted word
  `PISP_ASSERT_NOW(a_single_has_cause, $rose(rsp_valid) && (result_kind != pisp_pkg::KIND_CMD), $past(req_valid && req_ready), "result without a word")

  `PISP_ASSERT_NOW(a_err_count, rsp_valid && (result_kind == pisp_pkg::KIND_ERR), (result_value > pisp_pkg::WORD_W'(pisp_pkg::MAX_PARAMS)) && run_last, "error for a legal count")

endmodule

bind panel_init_sequence_parser pisp_props u_pisp_props (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_kind  (rsp.result_kind),
  .result_value (rsp.result_value),
  .run_last     (rsp.run_last)
);
